[hdl/sgauss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sgauss_pkg
// Shared types and constants for the separable 3x3 Gaussian unit.
// ----------------------------------------------------------------------------
package sgauss_pkg;

  localparam int DEFAULT_MAX_WIDTH = 2048;

  localparam logic [7:0]  RST_WEIGHT_LEFT   = 8'd64;
  localparam logic [7:0]  RST_WEIGHT_CENTRE = 8'd128;
  localparam logic [7:0]  RST_WEIGHT_RIGHT  = 8'd64;
  localparam logic [11:0] RST_LINE_WIDTH    = 12'd2048;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_WEIGHT_LEFT   = 2'd0;
  localparam logic [1:0] REG_WEIGHT_CENTRE = 2'd1;
  localparam logic [1:0] REG_WEIGHT_RIGHT  = 2'd2;
  localparam logic [1:0] REG_LINE_WIDTH    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM
  } sg_state_t;

  // line store command
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ls_ctrl_t;

endpackage
`default_nettype wire

[hdl/sgauss_line_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sgauss_line_store
// The two row-sum line stores. One read and one write address per cycle;
// read data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module sgauss_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire                    clk,
  input  wire sgauss_pkg::ls_ctrl_t ctrl,
  input  wire  [AW-1:0]          rd_addr,
  input  wire  [AW-1:0]          wr_addr,
  input  wire  [15:0]            wr_recent,
  output logic [15:0]            older_q,
  output logic [15:0]            recent_q
);
  import sgauss_pkg::*;

  logic [15:0] mem_older  [DEPTH];
  logic [15:0] mem_recent [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      older_q  <= mem_older[rd_addr];
      recent_q <= mem_recent[rd_addr];
    end
  end

  // the entry shifts one line down: recent moves to older
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem_older[wr_addr]  <= recent_q;
      mem_recent[wr_addr] <= wr_recent;
    end
  end

endmodule
`default_nettype wire

[hdl/separable_gaussian_3x3_u8_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// separable_gaussian_3x3_u8_unit
// Separable 3x3 weighted smoothing of an 8-bit raster stream.
// ----------------------------------------------------------------------------
// Each pixel runs through ST_IDLE, ST_READ and ST_SUM: the accept cycle forms
// the horizontal sum and reads the line-store entry of its column, ST_READ
// multiplies the stored row sums and writes the entry back, and ST_SUM adds,
// rounds and saturates into the output register. A new pixel is accepted
// only once the last is through, for the read-modify-write of its entry. A
// pending output held by out_stall keeps the unit in ST_SUM and blocks
// acceptance of the next pixel. The line stores need no initialization after
// reset; results start on the third column of the third line of a frame.
// ----------------------------------------------------------------------------
module separable_gaussian_3x3_u8_unit #(
  parameter int MAX_WIDTH = sgauss_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  pixel_in,
  input  wire         frame_start,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  pixel_out,
  output logic        row_end
);
  import sgauss_pkg::*;

  localparam int AW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int WWN = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WWN > 12) ? WWN : 12;

  // configuration
  logic [7:0]  weight_left, weight_centre, weight_right;
  logic [11:0] line_width;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_left   <= RST_WEIGHT_LEFT;
      weight_centre <= RST_WEIGHT_CENTRE;
      weight_right  <= RST_WEIGHT_RIGHT;
      line_width    <= RST_LINE_WIDTH;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WEIGHT_LEFT:   weight_left   <= pwdata[7:0];
        REG_WEIGHT_CENTRE: weight_centre <= pwdata[7:0];
        REG_WEIGHT_RIGHT:  weight_right  <= pwdata[7:0];
        REG_LINE_WIDTH:    line_width    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WEIGHT_LEFT:   prdata = {24'd0, weight_left};
      REG_WEIGHT_CENTRE: prdata = {24'd0, weight_centre};
      REG_WEIGHT_RIGHT:  prdata = {24'd0, weight_right};
      REG_LINE_WIDTH:    prdata = {20'd0, line_width};
      default:           prdata = '0;
    endcase
  end

  // control state
  sg_state_t   state, state_next;
  logic [15:0] pixel_history;
  logic [AW-1:0] column_count;
  logic [1:0]  row_count;

  // per-item registers
  logic [15:0]   hsum_q;
  logic [AW-1:0] addr_q;
  logic          wr_q, emit_q, last_q;
  logic [23:0]   prod_old, prod_rec, prod_new;

  // accept-cycle logic
  logic          accept;
  logic [EW-1:0] lw_ext, eff_w;
  logic [AW-1:0] c_cur, rd_addr;
  logic [1:0]    row_cur;
  logic [15:0]   hist_cur, hsum;
  logic          last, has_taps;
  ls_ctrl_t      ls_ctrl;
  logic [15:0]   older_q, recent_q;
  logic          load_out;

  assign accept = in_valid & ~in_stall;

  always_comb begin
    lw_ext = EW'(line_width);
    if (lw_ext < EW'(3)) begin
      eff_w = EW'(3);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
  end

  always_comb begin
    c_cur    = frame_start ? '0 : column_count;
    row_cur  = frame_start ? 2'd0 : row_count;
    hist_cur = frame_start ? 16'd0 : pixel_history;
    last     = EW'(c_cur) >= (eff_w - EW'(1));
    has_taps = c_cur >= AW'(2);
    rd_addr  = c_cur - AW'(2);
    hsum     = 16'(18'(weight_left)   * 18'(hist_cur[15:8]) +
                   18'(weight_centre) * 18'(hist_cur[7:0]) +
                   18'(weight_right)  * 18'(pixel_in));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_history <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else if (accept) begin
      pixel_history <= {hist_cur[7:0], pixel_in};
      if (last) begin
        column_count <= '0;
        if (row_cur < 2'd2) row_count <= row_cur + 2'd1;
        else                row_count <= row_cur;
      end else begin
        column_count <= c_cur + AW'(1);
        row_count    <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hsum_q <= hsum;
      addr_q <= rd_addr;
      last_q <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q   <= 1'b0;
      emit_q <= 1'b0;
    end else if (accept) begin
      wr_q   <= has_taps;
      emit_q <= has_taps & (row_cur == 2'd2);
    end
  end

  sgauss_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk       (clk),
    .ctrl      (ls_ctrl),
    .rd_addr   (rd_addr),
    .wr_addr   (addr_q),
    .wr_recent (hsum_q),
    .older_q   (older_q),
    .recent_q  (recent_q)
  );

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      prod_old <= 24'(weight_left)   * 24'(older_q);
      prod_rec <= 24'(weight_centre) * 24'(recent_q);
      prod_new <= 24'(weight_right)  * 24'(hsum_q);
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    ls_ctrl.rd_en = 1'b0;
    ls_ctrl.wr_en = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        ls_ctrl.rd_en = in_valid & has_taps;
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        ls_ctrl.wr_en = wr_q;
        state_next    = ST_SUM;
      end
      ST_SUM: begin
        if (!emit_q) begin
          state_next = ST_IDLE;
        end else if (!(out_valid && out_stall)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // vertical sum, round half up, saturate
  logic [25:0] vsum;
  logic [9:0]  vres;
  assign vsum = 26'(prod_old) + 26'(prod_rec) + 26'(prod_new) + 26'(16'h8000);
  assign vres = vsum[25:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pixel_out <= (vres > 10'd255) ? 8'hFF : vres[7:0];
      row_end   <= last_q;
    end
  end

endmodule
`default_nettype wire
